### design/svm_pkg.sv
// Package with the types, codes and constants of the stack machine executor.
package svm_pkg;

   localparam int unsigned DEPTH_DEFAULT = 1024;
   localparam int unsigned LIMIT_W       = 10;
   localparam int unsigned DEPTH_OUT_W   = 11;
   localparam int unsigned WORD_W        = 64;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 10'd1000;
   localparam logic [63:0] RET_FRAME  = 64'd4;
   localparam logic [63:0] SYS_OP_NOT = 64'd100;
   localparam logic [63:0] SYS_OP_ADD = 64'd200;
   localparam logic [63:0] SYS_OP_SUB = 64'd201;
   localparam logic [63:0] SYS_OP_MUL = 64'd202;
   localparam logic [63:0] SYS_OP_DIV = 64'd203;
   localparam logic [63:0] SYS_OP_EQ  = 64'd204;
   localparam logic [63:0] SYS_OP_LT  = 64'd205;
   localparam logic [63:0] SYS_OP_AND = 64'd206;
   localparam logic [63:0] SYS_OP_OR  = 64'd207;
   localparam logic [63:0] UNARY_CNT  = 64'd2;
   localparam logic [63:0] BINARY_CNT = 64'd3;
   localparam logic [63:0] LONG_STEP  = 64'd9;

   typedef enum logic [7:0] {
      OPC_EXIT    = 8'd0,
      OPC_ARG     = 8'd1,
      OPC_CALL    = 8'd2,
      OPC_JMP     = 8'd3,
      OPC_POP_JIF = 8'd4,
      OPC_PUSH    = 8'd5,
      OPC_RET     = 8'd6,
      OPC_SYSCALL = 8'd7
   } opcode_type;

   typedef enum logic [2:0] {
      ST_OK      = 3'd0,
      ST_EXIT    = 3'd1,
      ST_OVER    = 3'd2,
      ST_BAD     = 3'd3,
      ST_UNKNOWN = 3'd4
   } status_type;

   typedef enum logic [4:0] {
      CMD_NONE, CMD_LOAD, CMD_ERR_OVER, CMD_ERR_BAD, CMD_ERR_UNK, CMD_EXIT, CMD_JMP,
      CMD_PUSH, CMD_RD_ARG, CMD_WR_ARG, CMD_RD_TOP1, CMD_CALL_B, CMD_CALL_C, CMD_CALL_D,
      CMD_PJIF, CMD_RET_B, CMD_RET_C, CMD_RET_D, CMD_RET_E, CMD_SYS_B, CMD_SYS_C,
      CMD_SYS_NOT, CMD_SYS_D, CMD_SYS_ALU, CMD_MD_START, CMD_MD_TAKE, CMD_SYS_WR,
      CMD_RD_TOPV, CMD_RESULT
   } cmd_type;

   typedef enum logic [4:0] {
      S_IDLE, S_DEC, S_ARG, S_CALL_B, S_CALL_C, S_CALL_D, S_PJIF, S_RET_B, S_RET_C,
      S_RET_D, S_RET_E, S_SYS_B, S_SYS_C, S_SYS_NOT, S_SYS_D, S_SYS_E, S_MD, S_SYS_WR,
      S_TOP, S_RESULT
   } state_type;

   typedef struct packed {
      logic [7:0] opcode;
      logic       halted;
      logic       over_lim;
      logic       full;
      logic       arg_bad;
      logic       n_zero;
      logic       call_bad;
      logic       call_full;
      logic       ret_short;
      logic       ret_bad;
      logic       sys_bad;
      logic       cnt_zero;
      logic       sys_not;
      logic       sys_alu;
      logic       md_needed;
      logic       md_done;
      logic       rsp_free;
   } dp_status_type;

endpackage

### design/svm_if.sv
// Handshake interfaces for the instruction and result channels.
interface svm_req_if;
   logic        valid;
   logic        ready;
   logic [7:0]  opcode;
   logic [63:0] immediate;
   modport source (output valid, output opcode, output immediate, input ready);
   modport sink (input valid, input opcode, input immediate, output ready);
endinterface

interface svm_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [63:0] next_pointer;
   logic [63:0] top_value;
   logic [10:0] depth_now;
   modport source (output valid, output status, output next_pointer, output top_value,
                   output depth_now, input ready);
   modport sink (input valid, input status, input next_pointer, input top_value,
                 input depth_now, output ready);
endinterface

### design/svm_muldiv.sv
// Shared iterative unit for the 64-bit multiply and signed divide operations.
module svm_muldiv
   import svm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        is_div,
   input  logic [63:0] op_a,
   input  logic [63:0] op_b,
   output logic        done,
   output logic [63:0] result
);

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [63:0] acc_ff, acc_in;
   logic [63:0] x_ff, x_in;
   logic [63:0] y_ff, y_in;
   logic        neg_ff, neg_in;
   logic        div_ff, div_in;
   logic [64:0] rem_sh;
   logic [64:0] rem_sub;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      acc_in  = acc_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      neg_in  = neg_ff;
      div_in  = div_ff;
      rem_sh  = {acc_ff, x_ff[63]};
      rem_sub = rem_sh - {1'b0, y_ff};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         acc_in  = '0;
         div_in  = is_div;
         neg_in  = op_a[63] ^ op_b[63];
         if (is_div) begin
            x_in = op_a[63] ? -op_a : op_a;
            y_in = op_b[63] ? -op_b : op_b;
         end else begin
            x_in = op_a;
            y_in = op_b;
         end
      end else if (busy_ff) begin
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == '1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
         if (div_ff) begin
            if (!rem_sub[64]) begin
               acc_in = rem_sub[63:0];
               x_in   = {x_ff[62:0], 1'b1};
            end else begin
               acc_in = rem_sh[63:0];
               x_in   = {x_ff[62:0], 1'b0};
            end
         end else begin
            acc_in = acc_ff + (y_ff[0] ? x_ff : 64'd0);
            x_in   = {x_ff[62:0], 1'b0};
            y_in   = {1'b0, y_ff[63:1]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      acc_ff <= acc_in;
      x_ff   <= x_in;
      y_ff   <= y_in;
      neg_ff <= neg_in;
      div_ff <= div_in;
   end

   assign done   = done_ff;
   assign result = div_ff ? (neg_ff ? -x_ff : x_ff) : acc_ff;

endmodule

### design/svm_datapath.sv
// Datapath with the stack memory, machine registers and result register.
module svm_datapath
   import svm_pkg::*;
#(
   parameter int unsigned STACK_DEPTH = DEPTH_DEFAULT
)(
   input  logic                  clock,
   input  logic                  reset,
   input  cmd_type               cmd,
   output dp_status_type         status,
   input  logic                  csr_we,
   input  logic [LIMIT_W-1:0]    csr_wdata,
   input  logic [7:0]            req_opcode,
   input  logic [63:0]           req_immediate,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [2:0]            rsp_status,
   output logic [63:0]           rsp_next_pointer,
   output logic [63:0]           rsp_top_value,
   output logic [DEPTH_OUT_W-1:0] rsp_depth_now
);

   localparam int unsigned AW = $clog2(STACK_DEPTH);
   localparam int unsigned CW = $clog2(STACK_DEPTH + 1);

   logic [63:0]   mem [STACK_DEPTH];
   logic [63:0]   rd_ff;
   logic [CW-1:0] n_ff, n_in;
   logic [63:0]   fb_ff, fb_in;
   logic [63:0]   ip_ff, ip_in;
   logic          halted_ff, halted_in;
   status_type    hstat_ff, hstat_in;
   status_type    st_ff, st_in;
   logic [7:0]    opc_ff, opc_in;
   logic [63:0]   imm_ff, imm_in;
   logic [63:0]   a_ff, a_in;
   logic [63:0]   c_ff, c_in;
   logic [63:0]   op_ff, op_in;
   logic [63:0]   rv_ff, rv_in;
   logic [LIMIT_W-1:0] limit_ff;
   logic          ov_ff, ov_in;
   logic [2:0]    os_ff, os_in;
   logic [63:0]   oip_ff, oip_in;
   logic [63:0]   otop_ff, otop_in;
   logic [DEPTH_OUT_W-1:0] odep_ff, odep_in;
   logic          ren, wen;
   logic [AW-1:0] raddr, waddr;
   logic [63:0]   wdata;
   logic [63:0]   n64;
   logic [CW-1:0] m_ret, s_sys;
   logic [63:0]   alu_res;
   logic          md_start, md_done;
   logic [63:0]   md_result;

   assign n64   = 64'(n_ff);
   assign m_ret = n_ff - CW'(4) - CW'(c_ff);
   assign s_sys = n_ff - CW'(1) - CW'(c_ff);

   always_comb begin
      unique case (op_ff)
         SYS_OP_ADD: alu_res = a_ff + rd_ff;
         SYS_OP_SUB: alu_res = a_ff - rd_ff;
         SYS_OP_EQ:  alu_res = {63'd0, a_ff == rd_ff};
         SYS_OP_LT:  alu_res = {63'd0, $signed(a_ff) < $signed(rd_ff)};
         SYS_OP_AND: alu_res = {63'd0, (a_ff != 64'd0) && (rd_ff != 64'd0)};
         SYS_OP_OR:  alu_res = {63'd0, (a_ff != 64'd0) || (rd_ff != 64'd0)};
         default:    alu_res = '0;
      endcase
   end

   always_comb begin
      status.opcode    = opc_ff;
      status.halted    = halted_ff;
      status.over_lim  = n64 > 64'(limit_ff);
      status.full      = n64 >= 64'(STACK_DEPTH);
      status.arg_bad   = (imm_ff == 64'd0) || (imm_ff > n64);
      status.n_zero    = n_ff == '0;
      status.call_bad  = ($signed(rd_ff) < 64'sd1) || (rd_ff >= n64);
      status.call_full = (n64 + 64'd2) > 64'(STACK_DEPTH);
      status.ret_short = n64 < RET_FRAME;
      status.ret_bad   = rd_ff > (n64 - RET_FRAME);
      status.sys_bad   = rd_ff > (n64 - 64'd1);
      status.cnt_zero  = rd_ff == 64'd0;
      status.sys_not   = (c_ff == UNARY_CNT) && (rd_ff == SYS_OP_NOT);
      status.sys_alu   = (c_ff == BINARY_CNT) && (rd_ff >= SYS_OP_ADD) && (rd_ff <= SYS_OP_OR);
      status.md_needed = (op_ff == SYS_OP_MUL) || ((op_ff == SYS_OP_DIV) && (rd_ff != 64'd0));
      status.md_done   = md_done;
      status.rsp_free  = !ov_ff || rsp_ready;
   end

   always_comb begin
      n_in      = n_ff;
      fb_in     = fb_ff;
      ip_in     = ip_ff;
      halted_in = halted_ff;
      hstat_in  = hstat_ff;
      st_in     = st_ff;
      opc_in    = opc_ff;
      imm_in    = imm_ff;
      a_in      = a_ff;
      c_in      = c_ff;
      op_in     = op_ff;
      rv_in     = rv_ff;
      ov_in     = ov_ff && !rsp_ready;
      os_in     = os_ff;
      oip_in    = oip_ff;
      otop_in   = otop_ff;
      odep_in   = odep_ff;
      ren       = 1'b0;
      raddr     = AW'(n_ff - CW'(1));
      wen       = 1'b0;
      waddr     = AW'(n_ff);
      wdata     = imm_ff;
      md_start  = 1'b0;
      unique case (cmd)
         CMD_NONE: begin
         end
         CMD_LOAD: begin
            opc_in = req_opcode;
            imm_in = req_immediate;
            st_in  = halted_ff ? hstat_ff : ST_OK;
         end
         CMD_ERR_OVER: begin
            halted_in = 1'b1;
            hstat_in  = ST_OVER;
            st_in     = ST_OVER;
         end
         CMD_ERR_BAD: begin
            halted_in = 1'b1;
            hstat_in  = ST_BAD;
            st_in     = ST_BAD;
         end
         CMD_ERR_UNK: begin
            halted_in = 1'b1;
            hstat_in  = ST_UNKNOWN;
            st_in     = ST_UNKNOWN;
         end
         CMD_EXIT: begin
            ip_in     = ip_ff + 64'd1;
            halted_in = 1'b1;
            hstat_in  = ST_EXIT;
            st_in     = ST_EXIT;
         end
         CMD_JMP: ip_in = imm_ff;
         CMD_PUSH: begin
            wen   = 1'b1;
            n_in  = n_ff + CW'(1);
            ip_in = ip_ff + LONG_STEP;
         end
         CMD_RD_ARG: begin
            ren   = 1'b1;
            raddr = AW'(n_ff - CW'(imm_ff));
         end
         CMD_WR_ARG: begin
            wen   = 1'b1;
            wdata = rd_ff;
            n_in  = n_ff + CW'(1);
            ip_in = ip_ff + LONG_STEP;
         end
         CMD_RD_TOP1, CMD_RD_TOPV: ren = 1'b1;
         CMD_CALL_B: begin
            c_in  = rd_ff;
            ren   = 1'b1;
            raddr = AW'(n_ff - CW'(1) - CW'(rd_ff));
         end
         CMD_CALL_C: begin
            a_in  = rd_ff;
            wen   = 1'b1;
            wdata = fb_ff;
         end
         CMD_CALL_D: begin
            wen   = 1'b1;
            waddr = AW'(n_ff + CW'(1));
            wdata = ip_ff + 64'd1;
            n_in  = n_ff + CW'(2);
            fb_in = n64;
            ip_in = a_ff;
         end
         CMD_PJIF: begin
            ip_in = (rd_ff == 64'd0) ? imm_ff : ip_ff + LONG_STEP;
            n_in  = n_ff - CW'(1);
         end
         CMD_RET_B: begin
            a_in  = rd_ff;
            ren   = 1'b1;
            raddr = AW'(n_ff - CW'(4));
         end
         CMD_RET_C: begin
            c_in  = rd_ff;
            ren   = 1'b1;
            raddr = AW'(n_ff - CW'(2));
         end
         CMD_RET_D: begin
            ip_in = rd_ff;
            ren   = 1'b1;
            raddr = AW'(n_ff - CW'(3));
         end
         CMD_RET_E: begin
            fb_in = rd_ff;
            wen   = 1'b1;
            waddr = AW'(m_ret);
            wdata = a_ff;
            n_in  = m_ret + CW'(1);
         end
         CMD_SYS_B: begin
            c_in  = rd_ff;
            rv_in = '1;
            ren   = 1'b1;
            raddr = AW'(n_ff - CW'(2));
         end
         CMD_SYS_C: begin
            op_in = rd_ff;
            ren   = 1'b1;
            raddr = AW'(n_ff - CW'(3));
         end
         CMD_SYS_NOT: rv_in = {63'd0, rd_ff == 64'd0};
         CMD_SYS_D: begin
            a_in  = rd_ff;
            ren   = 1'b1;
            raddr = AW'(n_ff - CW'(4));
         end
         CMD_SYS_ALU:  rv_in = alu_res;
         CMD_MD_START: md_start = 1'b1;
         CMD_MD_TAKE:  rv_in = md_result;
         CMD_SYS_WR: begin
            wen   = 1'b1;
            waddr = AW'(s_sys);
            wdata = rv_ff;
            n_in  = s_sys + CW'(1);
            ip_in = ip_ff + 64'd1;
         end
         CMD_RESULT: begin
            ov_in   = 1'b1;
            os_in   = st_ff;
            oip_in  = ip_ff;
            otop_in = (n_ff == '0) ? 64'd0 : rd_ff;
            odep_in = DEPTH_OUT_W'(n_ff);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wen) begin
         mem[waddr] <= wdata;
      end
      if (ren) begin
         rd_ff <= mem[raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         n_ff      <= '0;
         fb_ff     <= '0;
         ip_ff     <= '0;
         halted_ff <= 1'b0;
         hstat_ff  <= ST_OK;
         limit_ff  <= LIMIT_RESET;
         ov_ff     <= 1'b0;
      end else begin
         n_ff      <= n_in;
         fb_ff     <= fb_in;
         ip_ff     <= ip_in;
         halted_ff <= halted_in;
         hstat_ff  <= hstat_in;
         ov_ff     <= ov_in;
         if (csr_we) begin
            limit_ff <= csr_wdata;
         end
      end
      st_ff   <= st_in;
      opc_ff  <= opc_in;
      imm_ff  <= imm_in;
      a_ff    <= a_in;
      c_ff    <= c_in;
      op_ff   <= op_in;
      rv_ff   <= rv_in;
      os_ff   <= os_in;
      oip_ff  <= oip_in;
      otop_ff <= otop_in;
      odep_ff <= odep_in;
   end

   svm_muldiv u_muldiv (
      .clock  (clock),
      .reset  (reset),
      .start  (md_start),
      .is_div (op_ff == SYS_OP_DIV),
      .op_a   (a_ff),
      .op_b   (rd_ff),
      .done   (md_done),
      .result (md_result)
   );

   assign rsp_valid        = ov_ff;
   assign rsp_status       = os_ff;
   assign rsp_next_pointer = oip_ff;
   assign rsp_top_value    = otop_ff;
   assign rsp_depth_now    = odep_ff;

   a_depth_bound: assert property (@(posedge clock) disable iff (reset)
      n64 <= 64'(STACK_DEPTH))
      else $error("stack count beyond the stack depth");
   a_halt_sticky: assert property (@(posedge clock) disable iff (reset)
      halted_ff |=> halted_ff)
      else $error("halt flag cleared without reset");
   a_halt_frozen: assert property (@(posedge clock) disable iff (reset)
      halted_ff |=> ($stable(ip_ff) && $stable(n_ff) && $stable(fb_ff)))
      else $error("machine state changed while halted");

endmodule

### design/svm_controller.sv
// Sequencer that steps each instruction through its memory accesses.
module svm_controller
   import svm_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  dp_status_type status,
   output cmd_type       cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = CMD_NONE;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd      = CMD_LOAD;
               state_in = S_DEC;
            end
         end
         S_DEC: begin
            state_in = S_TOP;
            if (status.halted) begin
               cmd = CMD_NONE;
            end else if (status.over_lim) begin
               cmd = CMD_ERR_OVER;
            end else begin
               unique case (status.opcode)
                  OPC_EXIT: cmd = CMD_EXIT;
                  OPC_ARG: begin
                     if (status.arg_bad) begin
                        cmd = CMD_ERR_BAD;
                     end else if (status.full) begin
                        cmd = CMD_ERR_OVER;
                     end else begin
                        cmd      = CMD_RD_ARG;
                        state_in = S_ARG;
                     end
                  end
                  OPC_CALL: begin
                     if (status.n_zero) begin
                        cmd = CMD_ERR_BAD;
                     end else begin
                        cmd      = CMD_RD_TOP1;
                        state_in = S_CALL_B;
                     end
                  end
                  OPC_JMP: cmd = CMD_JMP;
                  OPC_POP_JIF: begin
                     if (status.n_zero) begin
                        cmd = CMD_ERR_BAD;
                     end else begin
                        cmd      = CMD_RD_TOP1;
                        state_in = S_PJIF;
                     end
                  end
                  OPC_PUSH: cmd = status.full ? CMD_ERR_OVER : CMD_PUSH;
                  OPC_RET: begin
                     if (status.ret_short) begin
                        cmd = CMD_ERR_BAD;
                     end else begin
                        cmd      = CMD_RD_TOP1;
                        state_in = S_RET_B;
                     end
                  end
                  OPC_SYSCALL: begin
                     if (status.n_zero) begin
                        cmd = CMD_ERR_BAD;
                     end else begin
                        cmd      = CMD_RD_TOP1;
                        state_in = S_SYS_B;
                     end
                  end
                  default: cmd = CMD_ERR_UNK;
               endcase
            end
         end
         S_ARG: begin
            cmd      = CMD_WR_ARG;
            state_in = S_TOP;
         end
         S_CALL_B: begin
            priority if (status.call_bad) begin
               cmd      = CMD_ERR_BAD;
               state_in = S_TOP;
            end else if (status.call_full) begin
               cmd      = CMD_ERR_OVER;
               state_in = S_TOP;
            end else begin
               cmd      = CMD_CALL_B;
               state_in = S_CALL_C;
            end
         end
         S_CALL_C: begin
            cmd      = CMD_CALL_C;
            state_in = S_CALL_D;
         end
         S_CALL_D: begin
            cmd      = CMD_CALL_D;
            state_in = S_TOP;
         end
         S_PJIF: begin
            cmd      = CMD_PJIF;
            state_in = S_TOP;
         end
         S_RET_B: begin
            cmd      = CMD_RET_B;
            state_in = S_RET_C;
         end
         S_RET_C: begin
            if (status.ret_bad) begin
               cmd      = CMD_ERR_BAD;
               state_in = S_TOP;
            end else begin
               cmd      = CMD_RET_C;
               state_in = S_RET_D;
            end
         end
         S_RET_D: begin
            cmd      = CMD_RET_D;
            state_in = S_RET_E;
         end
         S_RET_E: begin
            cmd      = CMD_RET_E;
            state_in = S_TOP;
         end
         S_SYS_B: begin
            if (status.sys_bad) begin
               cmd      = CMD_ERR_BAD;
               state_in = S_TOP;
            end else begin
               cmd      = CMD_SYS_B;
               state_in = status.cnt_zero ? S_SYS_WR : S_SYS_C;
            end
         end
         S_SYS_C: begin
            priority if (status.sys_not) begin
               cmd      = CMD_SYS_C;
               state_in = S_SYS_NOT;
            end else if (status.sys_alu) begin
               cmd      = CMD_SYS_C;
               state_in = S_SYS_D;
            end else begin
               state_in = S_SYS_WR;
            end
         end
         S_SYS_NOT: begin
            cmd      = CMD_SYS_NOT;
            state_in = S_SYS_WR;
         end
         S_SYS_D: begin
            cmd      = CMD_SYS_D;
            state_in = S_SYS_E;
         end
         S_SYS_E: begin
            if (status.md_needed) begin
               cmd      = CMD_MD_START;
               state_in = S_MD;
            end else begin
               cmd      = CMD_SYS_ALU;
               state_in = S_SYS_WR;
            end
         end
         S_MD: begin
            if (status.md_done) begin
               cmd      = CMD_MD_TAKE;
               state_in = S_SYS_WR;
            end
         end
         S_SYS_WR: begin
            cmd      = CMD_SYS_WR;
            state_in = S_TOP;
         end
         S_TOP: begin
            cmd      = CMD_RD_TOPV;
            state_in = S_RESULT;
         end
         S_RESULT: begin
            if (status.rsp_free) begin
               cmd      = CMD_RESULT;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

endmodule

### design/stack_vm_instruction_executor.sv
// Top level of the stack machine instruction executor.
// Each instruction steps through decode, its stack reads and writes, a read of the top of
// stack and the result register; a syscall multiply or divide uses the 64-step mul/div unit.
// One item is in work at a time; the result is registered once the result register is free,
// and the next item is accepted in the idle state that follows. Each step makes at most one
// stack access.
// Synchronous reset clears count, frame base, pointer and halt and sets the limit to 1000.
module stack_vm_instruction_executor
   import svm_pkg::*;
#(
   parameter int unsigned STACK_DEPTH = DEPTH_DEFAULT
)(
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_we,
   input  logic [LIMIT_W-1:0] csr_wdata,
   svm_req_if.sink            req_if,
   svm_rsp_if.source          rsp_if
);

   cmd_type       cmd;
   dp_status_type status;

   svm_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .status    (status),
      .cmd       (cmd)
   );

   svm_datapath #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .csr_we           (csr_we),
      .csr_wdata        (csr_wdata),
      .req_opcode       (req_if.opcode),
      .req_immediate    (req_if.immediate),
      .rsp_valid        (rsp_if.valid),
      .rsp_ready        (rsp_if.ready),
      .rsp_status       (rsp_if.status),
      .rsp_next_pointer (rsp_if.next_pointer),
      .rsp_top_value    (rsp_if.top_value),
      .rsp_depth_now    (rsp_if.depth_now)
   );

endmodule
